/* sv/frame_animation_sequencer_defines.svh */
// Assertion macros for the frame animation sequencer.
// Stand-alone header; the asserting module includes it by name.
`ifndef FRAME_ANIMATION_SEQUENCER_DEFINES_SVH
`define FRAME_ANIMATION_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define FAS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fas assertion failed");
`define FAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fas assertion failed");
`else
`define FAS_ASSERT_SAME(label, clk, rst, ante, cons)
`define FAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/fas_pkg.sv */
// Shared constants and codes for the frame animation sequencer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package fas_pkg;

   localparam int FRAME_BITS     = 8;
   localparam int COUNT_BITS     = 16;
   localparam int TICK_BITS      = COUNT_BITS + 1;
   localparam int TOTAL_BITS     = FRAME_BITS + 1;
   localparam int MODE_BITS      = 3;
   localparam int LFSR_BITS      = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [TOTAL_BITS-1:0] FRAME_LIMIT = TOTAL_BITS'(2 ** FRAME_BITS);
   localparam logic [FRAME_BITS-1:0] FRAME_MAX   = {FRAME_BITS{1'b1}};
   localparam logic [LFSR_BITS-1:0]  LFSR_SEED   = 16'hACE1;
   localparam logic [LFSR_BITS-1:0]  LFSR_TAPS   = 16'hB400;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_FORWARD  = 3'd0,
      MODE_BACKWARD = 3'd1,
      MODE_PINGPONG = 3'd2,
      MODE_RANDOM   = 3'd3,
      MODE_MANUAL   = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ANIM_MODE   = 4'd0,
      CSR_START_DELAY = 4'd1,
      CSR_FRAME_RATE  = 4'd2,
      CSR_FRAME_TOTAL = 4'd3
   } csr_index_type;

endpackage

/* sv/fas_channels.sv */
// Valid/ready channel interfaces: tick requests, frame responses, register writes.
// Depends on fas_pkg for payload widths.
`timescale 1ns / 1ps

interface fas_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface fas_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fas_pkg::FRAME_BITS-1:0] frame_index;
   logic                          frame_stepped;
   logic                          in_delay;
   modport source (output valid, output frame_index, output frame_stepped,
                   output in_delay, input ready);
   modport sink (input valid, input frame_index, input frame_stepped,
                 input in_delay, output ready);
endinterface

interface fas_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fas_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic [fas_pkg::CSR_DATA_BITS-1:0]  wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

/* sv/frame_animation_sequencer.sv */
// Frame animation sequencer top level: tick input stage, step logic, response register.
// Depends on fas_pkg, fas_channels and frame_animation_sequencer_defines.svh.
`timescale 1ns / 1ps
`include "frame_animation_sequencer_defines.svh"

// channel    direction  word
// req_chan   in         restart
// rsp_chan   out        frame_index, frame_stepped, in_delay
// csr_chan   in         reg_index, wr_data
//
// One tick a cycle while the response is not stalled; a tick waits in the input
// register and, when it advances, its response is loaded into the response register.
// The step logic and the LFSR-by-total product sit between those two registers.
// A stalled response holds the input register; req_chan.ready falls only then.
// Synchronous active-high reset sets the CSR, state and valid registers to
// their defaults and seeds the LFSR; csr_chan is always ready.

module frame_animation_sequencer (
   input  logic        clock,
   input  logic        reset,
   fas_req_if.sink     req_chan,
   fas_rsp_if.source   rsp_chan,
   fas_csr_if.sink     csr_chan
);

   logic [fas_pkg::MODE_BITS-1:0]   mode_ff;
   logic [fas_pkg::COUNT_BITS-1:0]  start_delay_ff;
   logic [fas_pkg::COUNT_BITS-1:0]  frame_rate_ff;
   logic [fas_pkg::TOTAL_BITS-1:0]  frame_total_ff;

   logic                            running_ff, running_in;
   logic [fas_pkg::TICK_BITS-1:0]   tick_ff, tick_in;
   logic [fas_pkg::FRAME_BITS-1:0]  frame_ff, frame_in;
   logic                            up_ff, up_in;
   logic                            playing_ff, playing_in;
   logic [fas_pkg::LFSR_BITS-1:0]   lfsr_ff, lfsr_in;

   logic                            in_valid_ff;
   logic                            in_restart_ff;
   logic                            rsp_valid_ff;
   logic [fas_pkg::FRAME_BITS-1:0]  rsp_frame_ff;
   logic                            rsp_stepped_ff, stepped_in;
   logic                            rsp_delay_ff;

   logic                            advance;
   logic                            csr_write;
   logic                            running_b, up_b, playing_b;
   logic [fas_pkg::TICK_BITS-1:0]   tick_b;
   logic [fas_pkg::FRAME_BITS-1:0]  frame_b;
   logic [fas_pkg::TOTAL_BITS-1:0]  total_eff, total_m1, frame_up;
   logic [fas_pkg::LFSR_BITS-1:0]   lfsr_next;
   logic [fas_pkg::LFSR_BITS+fas_pkg::TOTAL_BITS-1:0] rand_product;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_write = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready      = !in_valid_ff || advance;
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_index   = rsp_frame_ff;
   assign rsp_chan.frame_stepped = rsp_stepped_ff;
   assign rsp_chan.in_delay      = rsp_delay_ff;

   always_comb begin
      if (frame_total_ff == '0) begin
         total_eff = fas_pkg::TOTAL_BITS'(1);
      end else if (frame_total_ff > fas_pkg::FRAME_LIMIT) begin
         total_eff = fas_pkg::FRAME_LIMIT;
      end else begin
         total_eff = frame_total_ff;
      end
      total_m1 = total_eff - fas_pkg::TOTAL_BITS'(1);
   end

   always_comb begin
      lfsr_next = {1'b0, lfsr_ff[fas_pkg::LFSR_BITS-1:1]};
      if (lfsr_ff[0]) begin
         lfsr_next = lfsr_next ^ fas_pkg::LFSR_TAPS;
      end
      rand_product = lfsr_next * total_eff;
   end

   always_comb begin
      running_b = in_restart_ff ? 1'b0 : running_ff;
      tick_b    = in_restart_ff ? '0 : tick_ff;
      frame_b   = in_restart_ff ? '0 : frame_ff;
      up_b      = in_restart_ff ? 1'b1 : up_ff;
      playing_b = in_restart_ff ? (mode_ff != fas_pkg::MODE_MANUAL) : playing_ff;
      frame_up  = {1'b0, frame_b} + fas_pkg::TOTAL_BITS'(1);

      running_in = running_b;
      tick_in    = tick_b + fas_pkg::TICK_BITS'(1);
      frame_in   = frame_b;
      up_in      = up_b;
      playing_in = playing_b;
      lfsr_in    = lfsr_ff;
      stepped_in = 1'b0;

      if (!running_b) begin
         if (tick_in > {1'b0, start_delay_ff}) begin
            tick_in    = '0;
            running_in = 1'b1;
         end
      end else if (tick_in > {1'b0, frame_rate_ff}) begin
         tick_in = '0;
         if (playing_b) begin
            stepped_in = 1'b1;
            case (mode_ff)
               fas_pkg::MODE_FORWARD: begin
                  if (frame_up >= total_eff) begin
                     frame_in   = '0;
                     running_in = 1'b0;
                  end else begin
                     frame_in = frame_up[fas_pkg::FRAME_BITS-1:0];
                  end
               end
               fas_pkg::MODE_BACKWARD: begin
                  if (frame_b <= fas_pkg::FRAME_BITS'(1)) begin
                     frame_in   = total_m1[fas_pkg::FRAME_BITS-1:0];
                     running_in = 1'b0;
                  end else begin
                     frame_in = frame_b - fas_pkg::FRAME_BITS'(1);
                  end
               end
               fas_pkg::MODE_PINGPONG: begin
                  if (up_b) begin
                     if (frame_up >= total_m1) begin
                        up_in = 1'b0;
                     end
                     if (frame_up > {1'b0, fas_pkg::FRAME_MAX}) begin
                        frame_in = fas_pkg::FRAME_MAX;
                     end else begin
                        frame_in = frame_up[fas_pkg::FRAME_BITS-1:0];
                     end
                  end else if (frame_b <= fas_pkg::FRAME_BITS'(1)) begin
                     frame_in   = '0;
                     up_in      = 1'b1;
                     running_in = 1'b0;
                  end else begin
                     frame_in = frame_b - fas_pkg::FRAME_BITS'(1);
                  end
               end
               fas_pkg::MODE_RANDOM: begin
                  lfsr_in  = lfsr_next;
                  frame_in = rand_product[fas_pkg::LFSR_BITS +: fas_pkg::FRAME_BITS];
               end
               default: begin
                  frame_in = frame_b;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= fas_pkg::MODE_FORWARD;
         start_delay_ff <= '0;
         frame_rate_ff  <= '0;
         frame_total_ff <= fas_pkg::TOTAL_BITS'(1);
         running_ff     <= 1'b0;
         tick_ff        <= '0;
         frame_ff       <= '0;
         up_ff          <= 1'b1;
         playing_ff     <= 1'b1;
         lfsr_ff        <= fas_pkg::LFSR_SEED;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            running_ff   <= running_in;
            tick_ff      <= tick_in;
            frame_ff     <= frame_in;
            up_ff        <= up_in;
            playing_ff   <= playing_in;
            lfsr_ff      <= lfsr_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_chan.reg_index)
               fas_pkg::CSR_ANIM_MODE: begin
                  mode_ff    <= csr_chan.wr_data[fas_pkg::MODE_BITS-1:0];
                  playing_ff <= (csr_chan.wr_data[fas_pkg::MODE_BITS-1:0]
                                 != fas_pkg::MODE_MANUAL);
               end
               fas_pkg::CSR_START_DELAY: begin
                  start_delay_ff <= csr_chan.wr_data[fas_pkg::COUNT_BITS-1:0];
               end
               fas_pkg::CSR_FRAME_RATE: begin
                  frame_rate_ff <= csr_chan.wr_data[fas_pkg::COUNT_BITS-1:0];
               end
               fas_pkg::CSR_FRAME_TOTAL: begin
                  frame_total_ff <= csr_chan.wr_data[fas_pkg::TOTAL_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_restart_ff <= req_chan.restart;
      end
      if (advance) begin
         rsp_frame_ff   <= frame_in;
         rsp_stepped_ff <= stepped_in;
         rsp_delay_ff   <= !running_in;
      end
   end

   `FAS_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff)
   `FAS_ASSERT_NEXT(a_paused_never_steps, clock, reset,
      advance && !in_restart_ff && !playing_ff, !rsp_stepped_ff)
   `FAS_ASSERT_NEXT(a_restart_frame_zero, clock, reset, advance && in_restart_ff,
      (rsp_frame_ff == '0) && !rsp_stepped_ff)
   `FAS_ASSERT_SAME(a_stall_only_when_full, clock, reset, !req_chan.ready,
      in_valid_ff && rsp_valid_ff)

endmodule

/* dv/tb_frame_animation_sequencer.sv */
// Self-checking testbench for the frame animation sequencer: directed and random tick traffic.
// Depends on fas_pkg, fas_channels and the frame_animation_sequencer top level.
// A local model of the sequencer predicts each response word; a monitor checks them in order.
`timescale 1ns / 1ps

module tb_frame_animation_sequencer;

   localparam int LATENCY     = 2;
   localparam int STALL_LIMIT = 2000;
   localparam logic [fas_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 4'd15;

   typedef struct packed {
      logic [fas_pkg::FRAME_BITS-1:0] frame_index;
      logic                           frame_stepped;
      logic                           in_delay;
   } frame_word_type;

   logic clock;
   logic reset;

   fas_req_if req_bus ();
   fas_rsp_if rsp_bus ();
   fas_csr_if csr_bus ();

   frame_animation_sequencer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // sequencer model state and register copies
   logic                           running_q;
   logic [fas_pkg::TICK_BITS-1:0]  tick_q;
   logic [fas_pkg::FRAME_BITS-1:0] frame_q;
   logic                           going_up_q;
   logic                           playing_q;
   logic [fas_pkg::LFSR_BITS-1:0]  lfsr_q;
   logic [fas_pkg::MODE_BITS-1:0]  mode_q;
   logic [15:0]                    delay_q;
   logic [15:0]                    rate_q;
   logic [fas_pkg::TOTAL_BITS-1:0] total_q;

   frame_word_type pending_frames[$];
   int             error_count;
   int             source_idle_pct;
   int             sink_idle_pct;
   int             hold_req;
   int             hold_left;
   int             stalled_cycles;

   always #5 clock = ~clock;

   function automatic void restart_sequence();
      running_q  = 1'b0;
      tick_q     = '0;
      frame_q    = '0;
      going_up_q = 1'b1;
      playing_q  = (mode_q != fas_pkg::MODE_MANUAL);
   endfunction

   function automatic void reset_sequence_model();
      mode_q  = fas_pkg::MODE_FORWARD;
      delay_q = '0;
      rate_q  = '0;
      total_q = fas_pkg::TOTAL_BITS'(1);
      lfsr_q  = fas_pkg::LFSR_SEED;
      restart_sequence();
   endfunction

   function automatic void apply_register(input logic [fas_pkg::CSR_INDEX_BITS-1:0] idx,
                                          input logic [fas_pkg::CSR_DATA_BITS-1:0] data);
      case (idx)
         fas_pkg::CSR_ANIM_MODE: begin
            mode_q    = data[fas_pkg::MODE_BITS-1:0];
            playing_q = (mode_q != fas_pkg::MODE_MANUAL);
         end
         fas_pkg::CSR_START_DELAY: delay_q = data;
         fas_pkg::CSR_FRAME_RATE:  rate_q = data;
         fas_pkg::CSR_FRAME_TOTAL: total_q = data[fas_pkg::TOTAL_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic frame_word_type next_frame_word(input logic restart);
      frame_word_type w;
      int total;
      int f;
      w.frame_stepped = 1'b0;
      if (restart) restart_sequence();
      tick_q = tick_q + fas_pkg::TICK_BITS'(1);
      if (!running_q) begin
         if (tick_q > {1'b0, delay_q}) begin
            tick_q    = '0;
            running_q = 1'b1;
         end
      end else if (tick_q > {1'b0, rate_q}) begin
         tick_q = '0;
         if (playing_q) begin
            if (total_q == '0) total = 1;
            else if (total_q > fas_pkg::FRAME_LIMIT) total = int'(fas_pkg::FRAME_LIMIT);
            else total = int'(total_q);
            f = int'(frame_q);
            case (mode_q)
               fas_pkg::MODE_FORWARD: begin
                  f++;
                  if (f > total - 1) begin
                     f = 0;
                     running_q = 1'b0;
                  end
               end
               fas_pkg::MODE_BACKWARD: begin
                  f--;
                  if (f <= 0) begin
                     f = total - 1;
                     running_q = 1'b0;
                  end
               end
               fas_pkg::MODE_PINGPONG: begin
                  if (going_up_q) begin
                     f++;
                     if (f >= total - 1) going_up_q = 1'b0;
                     if (f > int'(fas_pkg::FRAME_MAX)) f = int'(fas_pkg::FRAME_MAX);
                  end else begin
                     f--;
                     if (f <= 0) begin
                        f          = 0;
                        going_up_q = 1'b1;
                        running_q  = 1'b0;
                     end
                  end
               end
               fas_pkg::MODE_RANDOM: begin
                  lfsr_q = {1'b0, lfsr_q[fas_pkg::LFSR_BITS-1:1]}
                           ^ (lfsr_q[0] ? fas_pkg::LFSR_TAPS : '0);
                  f = (int'(lfsr_q) * total) >>> 16;
               end
               default: ;
            endcase
            frame_q = f[fas_pkg::FRAME_BITS-1:0];
            w.frame_stepped = 1'b1;
         end
      end
      w.frame_index = frame_q;
      w.in_delay    = !running_q;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   // check responses in order, then predict newly accepted ticks
   always @(posedge clock) begin
      frame_word_type got;
      frame_word_type want;
      if (reset) begin
         reset_sequence_model();
         pending_frames.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready)
            apply_register(csr_bus.reg_index, csr_bus.wr_data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.frame_index   = rsp_bus.frame_index;
            got.frame_stepped = rsp_bus.frame_stepped;
            got.in_delay      = rsp_bus.in_delay;
            if (pending_frames.size() == 0) begin
               report_mismatch("unexpected word, frame_index", int'(got.frame_index), -1);
            end else begin
               want = pending_frames.pop_front();
               if (got.frame_index !== want.frame_index)
                  report_mismatch("frame_index", int'(got.frame_index), int'(want.frame_index));
               if (got.frame_stepped !== want.frame_stepped)
                  report_mismatch("frame_stepped", int'(got.frame_stepped),
                                  int'(want.frame_stepped));
               if (got.in_delay !== want.in_delay)
                  report_mismatch("in_delay", int'(got.in_delay), int'(want.in_delay));
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_frames.push_back(next_frame_word(req_bus.restart));
      end
   end

   // response side: random idling and long hold-offs
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (int'($urandom_range(99)) >= sink_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // leaves valid high; a drain lowers it, or the next call while it idles
   task automatic send_tick(input logic restart);
      while (int'($urandom_range(99)) < source_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_sequencer();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_register(input logic [fas_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [fas_pkg::CSR_DATA_BITS-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] mode, input logic [15:0] delay,
                            input logic [15:0] rate, input logic [15:0] total);
      drain_sequencer();
      write_register(fas_pkg::CSR_ANIM_MODE, mode);
      write_register(fas_pkg::CSR_START_DELAY, delay);
      write_register(fas_pkg::CSR_FRAME_RATE, rate);
      write_register(fas_pkg::CSR_FRAME_TOTAL, total);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_count();
      int sel = int'($urandom_range(99));
      if (sel < 70) return 16'($urandom_range(3));
      if (sel < 90) return 16'($urandom_range(20));
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic [15:0] pick_total();
      int sel = int'($urandom_range(99));
      if (sel < 40) return 16'($urandom_range(1, 8));
      if (sel < 70) return 16'($urandom_range(1, 256));
      if (sel < 90) begin
         case ($urandom_range(3))
            0: return 16'd1;
            1: return 16'd2;
            2: return 16'd255;
            default: return 16'd256;
         endcase
      end
      if ($urandom_range(1) == 0) return 16'd0;
      return 16'($urandom_range(257, 511));
   endfunction

   function automatic logic [15:0] pick_mode();
      if ($urandom_range(9) == 0) return 16'($urandom_range(5, 7));
      return 16'($urandom_range(0, 4));
   endfunction

   task automatic test_reset_state();
      repeat (3) send_tick(1'b0);
   endtask

   task automatic test_forward_backward();
      configure(16'(fas_pkg::MODE_FORWARD), 16'd0, 16'd0, 16'd2);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      configure(16'(fas_pkg::MODE_BACKWARD), 16'd0, 16'd0, 16'd3);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
   endtask

   task automatic test_pingpong();
      configure(16'(fas_pkg::MODE_PINGPONG), 16'd0, 16'd0, 16'd1);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
   endtask

   task automatic test_random_manual_undefined();
      configure(16'(fas_pkg::MODE_RANDOM), 16'd0, 16'd0, 16'd256);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      configure(16'(fas_pkg::MODE_MANUAL), 16'd0, 16'd0, 16'd4);
      send_tick(1'b1);
      send_tick(1'b0);
      configure(16'hFFFF, 16'd0, 16'd0, 16'd4);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   task automatic test_extremes();
      configure(16'(fas_pkg::MODE_RANDOM), 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(1'b1);
      send_tick(1'b0);
      drain_sequencer();
      write_register(CSR_UNUSED, 16'hFFFF);
      write_register(fas_pkg::CSR_FRAME_TOTAL, 16'h0000);
      write_register(fas_pkg::CSR_START_DELAY, 16'h0000);
      csr_bus.valid <= 1'b0;
      send_tick(1'b1);
   endtask

   task automatic test_backpressure();
      configure(16'(fas_pkg::MODE_FORWARD), 16'd1, 16'd0, 16'd5);
      source_idle_pct = 0;
      sink_idle_pct   = 0;
      hold_req        = 40;
      send_tick(1'b1);
      repeat (19) send_tick(1'b0);
      drain_sequencer();
   endtask

   task automatic test_random_traffic(input int src_pct, input int snk_pct, input int segments);
      int n;
      source_idle_pct = src_pct;
      sink_idle_pct   = snk_pct;
      repeat (segments) begin
         drain_sequencer();
         if ($urandom_range(1) == 0) write_register(fas_pkg::CSR_ANIM_MODE, pick_mode());
         if ($urandom_range(1) == 0) write_register(fas_pkg::CSR_START_DELAY, pick_count());
         if ($urandom_range(1) == 0) write_register(fas_pkg::CSR_FRAME_RATE, pick_count());
         if ($urandom_range(1) == 0) write_register(fas_pkg::CSR_FRAME_TOTAL, pick_total());
         csr_bus.valid <= 1'b0;
         n = int'($urandom_range(8, 32));
         repeat (n) send_tick($urandom_range(19) == 0);
      end
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.restart   = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = '0;
      csr_bus.wr_data   = '0;
      error_count       = 0;
      hold_req          = 0;
      hold_left         = 0;
      stalled_cycles    = 0;
      source_idle_pct   = 17;
      sink_idle_pct     = 71;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_forward_backward();
      test_pingpong();
      test_random_manual_undefined();
      test_extremes();
      test_random_traffic(17, 71, 8);
      test_random_traffic(71, 17, 8);
      test_random_traffic(0, 0, 8);
      test_backpressure();

      drain_sequencer();
      if (pending_frames.size() != 0)
         report_mismatch("words outstanding", pending_frames.size(), 0);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
